// File: src/rsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants for the ray/sphere intersection block
// Word formats, internal widths and classification codes.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned EpsW        = 32;
  localparam logic [EpsW-1:0] EpsReset = EpsW'(1);
  localparam int unsigned QueueDepth  = 4;

  // exact widths of the quadratic terms
  localparam int unsigned EW = CoordW + 1;      // origin - centre
  localparam int unsigned AW = 2*CoordW + 2;    // a = dir.dir
  localparam int unsigned BW = 2*CoordW + 4;    // b = 2 dir.e
  localparam int unsigned CW = 2*CoordW + 4;    // c = e.e - r^2
  localparam int unsigned DW = 4*CoordW + 8;    // discriminant
  localparam int unsigned SW = DW / 2;          // square root
  localparam int unsigned NW = 2*CoordW + 6;    // -b +/- root

  localparam logic [1:0] HitsNone = 2'd0;
  localparam logic [1:0] HitsOne  = 2'd1;
  localparam logic [1:0] HitsTwo  = 2'd2;

  typedef enum logic [1:0] {
    CLS_MISS    = 2'd0,
    CLS_TANGENT = 2'd1,
    CLS_SECANT  = 2'd2
  } cls_e;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic        [CoordW-2:0] radius;
  } ray_t;

  typedef struct packed {
    logic        [1:0]        hit_count;
    logic signed [CoordW-1:0] t_near;
    logic signed [CoordW-1:0] t_far;
    logic                     degenerate;
  } hit_t;

  typedef struct packed {
    cls_e cls;
    logic deg;
  } tag_t;

  typedef struct packed {
    tag_t                 tag;
    logic signed [AW-1:0] a;
    logic signed [BW-1:0] b;
    logic signed [DW-1:0] d;
  } mid_t;

endpackage

// File: src/rsi_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_fifo: small first-word-fall-through queue
// Registered occupancy count; full and empty are decoded from it.
// ----------------------------------------------------------------------------
module rsi_fifo import rsi_pkg::*; #(
  parameter type         T     = logic,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NCW = $clog2(Depth + 1);
  localparam logic [PW-1:0]  Last = PW'(Depth - 1);
  localparam logic [NCW-1:0] Full = NCW'(Depth);

  T               mem_q [Depth];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [NCW-1:0] cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == Last) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == Last) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NCW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// File: src/rsi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_front: quadratic set-up and classification
// Seven stages: offset, products, sums, partial squares, square sums,
// discriminant, classify.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ray_t            ray_i,
  input  logic [EpsW-1:0] eps_i,
  output logic            valid_o,
  output mid_t            mid_o
);

  // split points for the wide squares
  localparam int unsigned BL = BW / 2;
  localparam int unsigned BH = BW - BL;
  localparam int unsigned AL = AW / 2;
  localparam int unsigned AH = AW - AL;
  localparam int unsigned CL = CW / 2;
  localparam int unsigned CH = CW - CL;

  logic [6:0] v_q;

  logic signed [CoordW-1:0] org [3];
  logic signed [CoordW-1:0] ctr [3];
  logic signed [CoordW-1:0] dir [3];

  // stage 1
  logic signed [EW-1:0]     e_q  [3];
  logic signed [CoordW-1:0] dv_q [3];
  logic        [CoordW-2:0] r_q;
  logic                     deg1_q;
  // stage 2
  logic signed [2*CoordW-1:0]  dd_q [3];
  logic signed [CoordW+EW-1:0] de_q [3];
  logic signed [2*EW-1:0]      ee_q [3];
  logic        [2*CoordW-3:0]  rr_q;
  logic                        deg2_q;
  // stage 3
  logic signed [AW-1:0] a3_q;
  logic signed [BW-1:0] b3_q;
  logic signed [CW-1:0] c3_q;
  logic                 deg3_q;
  // stage 4: partial products of b*b and a*c
  logic signed [BH-1:0]      bh;
  logic        [BL-1:0]      bl;
  logic signed [AH-1:0]      ah;
  logic        [AL-1:0]      al;
  logic signed [CH-1:0]      ch;
  logic        [CL-1:0]      cl;
  logic signed [2*BH-1:0]    bhh_q;
  logic signed [BH+BL:0]     bhl_q;
  logic        [2*BL-1:0]    bll_q;
  logic signed [AH+CH-1:0]   ahch_q;
  logic signed [AH+CL:0]     ahcl_q;
  logic signed [AL+CH:0]     alch_q;
  logic        [AL+CL-1:0]   alcl_q;
  logic signed [AW-1:0]      a4_q;
  logic signed [BW-1:0]      b4_q;
  logic                      deg4_q;
  // stage 5
  logic signed [DW-1:0] bb_q;
  logic signed [DW-1:0] ac_q;
  logic signed [AW-1:0] a5_q;
  logic signed [BW-1:0] b5_q;
  logic                 deg5_q;
  // stage 6
  logic signed [DW-1:0] d6_q;
  logic signed [AW-1:0] a6_q;
  logic signed [BW-1:0] b6_q;
  logic                 deg6_q;
  // stage 7
  mid_t mid_q, mid_d;

  assign org = '{ray_i.origin_x, ray_i.origin_y, ray_i.origin_z};
  assign ctr = '{ray_i.center_x, ray_i.center_y, ray_i.center_z};
  assign dir = '{ray_i.dir_x, ray_i.dir_y, ray_i.dir_z};

  assign bh = $signed(b3_q[BW-1:BL]);
  assign bl = b3_q[BL-1:0];
  assign ah = $signed(a3_q[AW-1:AL]);
  assign al = a3_q[AL-1:0];
  assign ch = $signed(c3_q[CW-1:CL]);
  assign cl = c3_q[CL-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_comb begin
    mid_d     = '0;
    mid_d.a   = a6_q;
    mid_d.b   = b6_q;
    mid_d.d   = d6_q;
    mid_d.tag.deg = deg6_q;
    if (deg6_q || d6_q[DW-1]) begin
      mid_d.tag.cls = CLS_MISS;
    end else if ((d6_q[DW-1:EpsW] == '0) && (d6_q[EpsW-1:0] < eps_i)) begin
      mid_d.tag.cls = CLS_TANGENT;
    end else begin
      mid_d.tag.cls = CLS_SECANT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        e_q[i]  <= EW'(org[i]) - EW'(ctr[i]);
        dv_q[i] <= dir[i];
        dd_q[i] <= dv_q[i] * dv_q[i];
        de_q[i] <= dv_q[i] * e_q[i];
        ee_q[i] <= e_q[i] * e_q[i];
      end
      r_q    <= ray_i.radius;
      deg1_q <= (ray_i.dir_x == '0) && (ray_i.dir_y == '0) && (ray_i.dir_z == '0);
      rr_q   <= r_q * r_q;
      deg2_q <= deg1_q;

      a3_q   <= AW'(dd_q[0]) + AW'(dd_q[1]) + AW'(dd_q[2]);
      b3_q   <= (BW'(de_q[0]) + BW'(de_q[1]) + BW'(de_q[2])) <<< 1;
      c3_q   <= CW'(ee_q[0]) + CW'(ee_q[1]) + CW'(ee_q[2]) - $signed(CW'(rr_q));
      deg3_q <= deg2_q;

      bhh_q  <= bh * bh;
      bhl_q  <= bh * $signed({1'b0, bl});
      bll_q  <= bl * bl;
      ahch_q <= ah * ch;
      ahcl_q <= ah * $signed({1'b0, cl});
      alch_q <= $signed({1'b0, al}) * ch;
      alcl_q <= al * cl;
      a4_q   <= a3_q;
      b4_q   <= b3_q;
      deg4_q <= deg3_q;

      bb_q   <= (DW'(bhh_q) <<< (2 * BL)) + (DW'(bhl_q) <<< (BL + 1))
                + $signed(DW'(bll_q));
      ac_q   <= (DW'(ahch_q) <<< (AL + CL)) + (DW'(ahcl_q) <<< AL)
                + (DW'(alch_q) <<< CL) + $signed(DW'(alcl_q));
      a5_q   <= a4_q;
      b5_q   <= b4_q;
      deg5_q <= deg4_q;

      d6_q   <= bb_q - (ac_q <<< 2);
      a6_q   <= a5_q;
      b6_q   <= b5_q;
      deg6_q <= deg5_q;

      mid_q  <= mid_d;
    end
  end

  assign valid_o = v_q[6];
  assign mid_o   = mid_q;

endmodule

// File: src/rsi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_div: pipelined restoring divider
// One quotient bit per stage, magnitude in, sign and tag carried along.
// ----------------------------------------------------------------------------
module rsi_div import rsi_pkg::*; #(
  parameter int unsigned XW = 88,
  parameter int unsigned YW = AW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [XW-1:0] m_i,
  input  logic [YW-1:0] y_i,
  input  logic          neg_i,
  input  tag_t          tag_i,
  output logic          valid_o,
  output logic [XW-1:0] q_o,
  output logic          neg_o,
  output tag_t          tag_o
);

  logic [XW:0]   v_q;
  logic [XW-1:0] m_q   [XW+1];
  logic [XW-1:0] q_q   [XW+1];
  logic [YW-1:0] rem_q [XW+1];
  logic [YW-1:0] y_q   [XW+1];
  logic          neg_q [XW+1];
  tag_t          tag_q [XW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[XW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]   <= m_i;
      q_q[0]   <= '0;
      rem_q[0] <= '0;
      y_q[0]   <= y_i;
      neg_q[0] <= neg_i;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar k = 0; k < XW; k++) begin : g_step
    logic [YW:0] r, diff;
    logic        ge;
    assign r    = {rem_q[k], m_q[k][XW-1]};
    assign diff = r - {1'b0, y_q[k]};
    assign ge   = (r >= {1'b0, y_q[k]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[k+1]   <= {m_q[k][XW-2:0], 1'b0};
        q_q[k+1]   <= {q_q[k][XW-2:0], ge};
        rem_q[k+1] <= ge ? diff[YW-1:0] : r[YW-1:0];
        y_q[k+1]   <= y_q[k];
        neg_q[k+1] <= neg_q[k];
        tag_q[k+1] <= tag_q[k];
      end
    end
  end

  assign valid_o = v_q[XW];
  assign q_o     = q_q[XW];
  assign neg_o   = neg_q[XW];
  assign tag_o   = tag_q[XW];

endmodule

// File: src/rsi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsi_back: root, line parameters and saturation
// Bit-pair square root pipeline, numerator set-up, two dividers, clamp.
// ----------------------------------------------------------------------------
module rsi_back import rsi_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  mid_t mid_i,
  output logic valid_o,
  output hit_t hit_o
);

  localparam int unsigned RW = SW + 3;
  localparam int unsigned XW = NW + FracBits + 2;
  localparam int unsigned YW = AW;
  localparam logic [XW-1:0] PosLim = XW'({(CoordW-1){1'b1}});
  localparam logic [XW-1:0] NegLim = PosLim + XW'(1);

  // square root pipeline
  logic [SW:0]          sv_q;
  logic [DW-1:0]        sn_q    [SW+1];
  logic [RW-1:0]        srem_q  [SW+1];
  logic [SW-1:0]        sroot_q [SW+1];
  tag_t                 stag_q  [SW+1];
  logic signed [AW-1:0] sa_q    [SW+1];
  logic signed [BW-1:0] sb_q    [SW+1];

  // numerator stages
  logic [2:0]           nv_q;
  logic signed [NW-1:0] num1_q [2];
  logic [YW-1:0]        y1_q, y2_q, y3_q;
  tag_t                 tag1_q, tag2_q, tag3_q;
  logic signed [XW-1:0] x2_q [2];
  logic [XW-1:0]        m3_q [2];
  logic                 neg3_q [2];
  logic [NW-1:0]        root_ext;
  logic signed [NW-1:0] nb;

  // divider outputs
  logic          dv  [2];
  logic [XW-1:0] dq  [2];
  logic          dng [2];
  tag_t          dtg [2];

  logic fv_q;
  hit_t hit_q, hit_d;

  function automatic logic signed [CoordW-1:0] clamp(input logic [XW-1:0] q,
                                                     input logic neg);
    logic [XW-1:0] t;
    t = ~q + XW'(1);
    if (!neg) begin
      clamp = (q > PosLim) ? PosLim[CoordW-1:0] : q[CoordW-1:0];
    end else begin
      clamp = (q > NegLim) ? NegLim[CoordW-1:0] : t[CoordW-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      nv_q <= '0;
      fv_q <= 1'b0;
    end else if (en_i) begin
      sv_q <= {sv_q[SW-1:0], valid_i};
      nv_q <= {nv_q[1:0], sv_q[SW]};
      fv_q <= dv[0] && dv[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q[0]    <= (mid_i.tag.cls == CLS_SECANT) ? mid_i.d : '0;
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      stag_q[0]  <= mid_i.tag;
      sa_q[0]    <= mid_i.a;
      sb_q[0]    <= mid_i.b;
    end
  end

  for (genvar k = 0; k < SW; k++) begin : g_root
    logic [RW-1:0] r2, trial;
    logic          ge;
    assign r2    = {srem_q[k][RW-3:0], sn_q[k][DW-1:DW-2]};
    assign trial = RW'({sroot_q[k], 2'b01});
    assign ge    = (r2 >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sn_q[k+1]    <= {sn_q[k][DW-3:0], 2'b00};
        srem_q[k+1]  <= ge ? r2 - trial : r2;
        sroot_q[k+1] <= {sroot_q[k][SW-2:0], ge};
        stag_q[k+1]  <= stag_q[k];
        sa_q[k+1]    <= sa_q[k];
        sb_q[k+1]    <= sb_q[k];
      end
    end
  end

  // tangent hits use a zero root, so the near path gives -b/2a
  assign root_ext = (stag_q[SW].cls == CLS_SECANT) ? NW'(sroot_q[SW]) : '0;
  assign nb       = -NW'(sb_q[SW]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num1_q[0] <= nb - $signed(root_ext);
      num1_q[1] <= nb + $signed(root_ext);
      y1_q      <= {sa_q[SW][AW-3:0], 2'b00};
      tag1_q    <= stag_q[SW];

      for (int i = 0; i < 2; i++) begin
        x2_q[i] <= (XW'(num1_q[i]) <<< (FracBits + 1))
                   + $signed(XW'(y1_q[YW-1:1]));
        m3_q[i]   <= x2_q[i][XW-1] ? ~x2_q[i] + XW'(y2_q) : x2_q[i];
        neg3_q[i] <= x2_q[i][XW-1];
      end
      y2_q   <= y1_q;
      tag2_q <= tag1_q;
      y3_q   <= y2_q;
      tag3_q <= tag2_q;
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_div
    rsi_div #(
      .XW(XW),
      .YW(YW)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(nv_q[2]),
      .m_i    (m3_q[i]),
      .y_i    (y3_q),
      .neg_i  (neg3_q[i]),
      .tag_i  (tag3_q),
      .valid_o(dv[i]),
      .q_o    (dq[i]),
      .neg_o  (dng[i]),
      .tag_o  (dtg[i])
    );
  end

  always_comb begin
    hit_d            = '0;
    hit_d.degenerate = dtg[0].deg;
    case (dtg[0].cls)
      CLS_SECANT:  hit_d.hit_count = HitsTwo;
      CLS_TANGENT: hit_d.hit_count = HitsOne;
      default:     hit_d.hit_count = HitsNone;
    endcase
    if (dtg[0].cls != CLS_MISS) begin
      hit_d.t_near = clamp(dq[0], dng[0]);
    end
    if (dtg[1].cls == CLS_SECANT) begin
      hit_d.t_far = clamp(dq[1], dng[1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = fv_q;
  assign hit_o   = hit_q;

endmodule

// File: src/ray_sphere_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect: line/sphere intersection test
// Queue-style ports; one result word per ray word, in order.
// ----------------------------------------------------------------------------
// Takes one ray/sphere word per clock while full is low and returns one
// result word per clock while results are popped. The line parameters are
// the roots of a*t^2 + b*t + c = 0, solved exactly with full-width
// products; t is rounded to nearest (ties upward) and saturated to signed
// Q16.16. A discriminant in [0, tangent_epsilon) gives a single tangent hit
// with t_far = 0; a zero direction sets degenerate with no hits. A word
// passes, in order, set-up and classification, the middle queue, the square
// root (one bit pair a stage), the numerators, the dividers (one quotient
// bit a stage), the clamp and the output queue; the root is SW =
// 2*COORD_WIDTH+4 bits wide and each quotient XW = 2*COORD_WIDTH+FRAC_BITS+8.
// The set-up front end and the root/divide back end are joined by a short
// queue and each stalls only when the queue in front of it is full; full and
// empty are decoded from a registered occupancy count.
// tangent_epsilon resets to 1 and should be written only while idle.
// ----------------------------------------------------------------------------
module ray_sphere_intersect import rsi_pkg::*; #(
  parameter int unsigned FRAC_BITS   = FracBitsDef,
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // ray words in
  input  logic            push,
  output logic            full,
  input  ray_t            ray_i,
  // result words out
  output logic            empty,
  input  logic            pop,
  output hit_t            hit_o,
  // tangent threshold register
  input  logic            cfg_we_i,
  input  logic [EpsW-1:0] cfg_wdata_i
);

  logic [EpsW-1:0] eps_q;

  // front end -> middle queue
  logic front_en, front_v;
  mid_t front_word;
  logic midq_full, midq_empty, midq_pop;
  mid_t midq_word;

  // back end -> output queue
  logic back_en, back_v;
  hit_t back_word;
  logic outq_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // The front end only moves while the middle queue has room, so a frozen
  // last stage keeps its word until it can be written.
  assign front_en = !midq_full;
  assign full     = midq_full;

  rsi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (front_en),
    .valid_i(push),
    .ray_i  (ray_i),
    .eps_i  (eps_q),
    .valid_o(front_v),
    .mid_o  (front_word)
  );

  rsi_fifo #(
    .T    (mid_t),
    .Depth(QUEUE_DEPTH)
  ) u_midq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_en && front_v),
    .data_i (front_word),
    .pop_i  (midq_pop),
    .data_o (midq_word),
    .full_o (midq_full),
    .empty_o(midq_empty)
  );

  // Same scheme on the back end against the output queue.
  assign back_en  = !outq_full;
  assign midq_pop = back_en && !midq_empty;

  rsi_back #(
    .FracBits(FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (back_en),
    .valid_i(!midq_empty),
    .mid_i  (midq_word),
    .valid_o(back_v),
    .hit_o  (back_word)
  );

  rsi_fifo #(
    .T    (hit_t),
    .Depth(QUEUE_DEPTH)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_en && back_v),
    .data_i (back_word),
    .pop_i  (pop),
    .data_o (hit_o),
    .full_o (outq_full),
    .empty_o(empty)
  );

  // a waiting result is never dropped or altered before it is taken
  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(hit_o))
    else $error("result word changed while waiting");

  // degenerate rays report no hits
  a_deg_no_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && hit_o.degenerate |-> hit_o.hit_count == HitsNone)
    else $error("degenerate ray with hits");

  a_hit_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> hit_o.hit_count == HitsNone || hit_o.hit_count == HitsOne
               || hit_o.hit_count == HitsTwo)
    else $error("bad hit count");

  // a full front stays full until the back end drains the middle queue
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !midq_pop |=> full)
    else $error("middle queue lost a word");

endmodule
